// ===== rtl/core/emt_pkg.sv =====
package emt_pkg;

	// fixed field widths
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned IDX_N   = 1 << IDX_W;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned HALF_W  = TIME_W / 2;

	// smoothing: new = (127 * old + x + 64) >>> 7
	localparam int unsigned SMOOTH_SHIFT = 7;
	localparam logic [TIME_W-1:0] SMOOTH_ROUND = TIME_W'(1) << (SMOOTH_SHIFT - 1);

	localparam logic REQ_TIMED = 1'b0;
	localparam logic REQ_COUNT = 1'b1;

	localparam logic KIND_COUNTED = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  total;
		logic [TIME_W-1:0]  mean;
		logic [TIME_W-1:0]  variance;
		logic [TIME_W-1:0]  third;
		logic               kind;
	} emt_entry_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic issue;   // start a 32x32 product this cycle
		logic clear;   // product replaces the accumulator
		logic high;    // product lands in the upper half
	} emt_mul_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_MEAN,
		ST_DIFF,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_SQW,
		ST_VAR,
		ST_CU1,
		ST_CU2,
		ST_CUW,
		ST_THIRD,
		ST_WRITE
	} emt_state_t;

endpackage

// ===== rtl/core/emt_ram.sv =====
module emt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/emt_mul.sv =====
module emt_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  emt_pkg::emt_mul_op_t        op,
	input  logic [emt_pkg::HALF_W-1:0]  a,
	input  logic [emt_pkg::HALF_W-1:0]  b,
	output logic [emt_pkg::TIME_W-1:0]  acc
);

	logic [emt_pkg::TIME_W-1:0] prod;
	logic [emt_pkg::TIME_W-1:0] prod_s1;
	emt_pkg::emt_mul_op_t       op_s1;
	logic [emt_pkg::TIME_W-1:0] addend;
	logic [emt_pkg::TIME_W-1:0] acc_q;

	assign prod = emt_pkg::TIME_W'(a) * emt_pkg::TIME_W'(b);

	always_ff @(posedge clk) begin
		if (op.issue) begin
			prod_s1 <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	// cross terms only matter in their low half, mod 2^64
	assign addend = op_s1.high ? {prod_s1[emt_pkg::HALF_W-1:0], {emt_pkg::HALF_W{1'b0}}}
	                           : prod_s1;

	always_ff @(posedge clk) begin
		if (op_s1.issue) begin
			acc_q <= (op_s1.clear ? '0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/core/event_moment_tracker.sv =====
// Per-event statistics table of NUM_EVENTS entries: count, total time and
// smoothed mean, variance and third moment (factor 1/128, rounded, 64-bit
// wrap). event_index is reduced modulo NUM_EVENTS. After reset the table is
// zeroed by a clearing pass over all NUM_EVENTS entries with in_stall high.
// A count event, or a timed sample that lands on a zero mean, goes from fetch
// straight to write-back; a timed sample that smooths runs the mean and
// deviation steps, then the variance and third-moment steps on the single
// 32x32 multiply-accumulate unit, which forms the square and the cube of the
// deviation from three partial products each. One item is in work at a time;
// a finished result waits in the output register while the next word is taken.
module event_moment_tracker #(
	parameter int unsigned NUM_EVENTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [5:0]         event_index,
	input  logic signed [63:0] sample_time,
	input  logic signed [31:0] event_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         entry_index,
	output logic signed [31:0] entry_count,
	output logic signed [63:0] entry_total,
	output logic signed [63:0] entry_mean,
	output logic signed [63:0] entry_variance,
	output logic signed [63:0] entry_third,
	output logic               entry_kind
);

	localparam int unsigned AW = $clog2(NUM_EVENTS);
	localparam int unsigned EW = $bits(emt_pkg::emt_entry_t);
	localparam int unsigned TW = emt_pkg::TIME_W;
	localparam int unsigned HW = emt_pkg::HALF_W;
	localparam int unsigned CW = emt_pkg::COUNT_W;
	localparam int unsigned XW = emt_pkg::IDX_W;

	function automatic logic [emt_pkg::IDX_N-1:0][XW-1:0] build_mod_lut();
		logic [emt_pkg::IDX_N-1:0][XW-1:0] lut;
		for (int i = 0; i < emt_pkg::IDX_N; i++) begin
			lut[i] = XW'(i % NUM_EVENTS);
		end
		return lut;
	endfunction

	localparam logic [emt_pkg::IDX_N-1:0][XW-1:0] MOD_LUT = build_mod_lut();

	function automatic logic [TW-1:0] smooth(input logic [TW-1:0] old, input logic [TW-1:0] x);
		logic [TW-1:0] s;
		s = (old << emt_pkg::SMOOTH_SHIFT) - old + x + emt_pkg::SMOOTH_ROUND;
		return {{emt_pkg::SMOOTH_SHIFT{s[TW-1]}}, s[TW-1:emt_pkg::SMOOTH_SHIFT]};
	endfunction

	emt_pkg::emt_state_t  state_q, state_d;
	logic [AW-1:0]        clr_q;
	logic                 req_q;
	logic [XW-1:0]        idx_q;
	logic [TW-1:0]        t_q;
	logic [CW-1:0]        cnt_q;
	emt_pkg::emt_entry_t  entry_q;
	emt_pkg::emt_entry_t  rd_entry;
	emt_pkg::emt_entry_t  fetch_upd;
	logic [TW-1:0]        d_q;
	logic [TW-1:0]        sq_q;
	emt_pkg::emt_entry_t  out_q;
	logic [XW-1:0]        out_idx_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 proceed;
	logic [XW-1:0]        red_idx;
	logic [AW+XW-1:0]     in_addr_ext;
	logic [AW+XW-1:0]     wr_addr_ext;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [EW-1:0]        ram_wdata;
	logic [EW-1:0]        ram_rdata;
	emt_pkg::emt_mul_op_t mul_op;
	logic [HW-1:0]        mul_a;
	logic [HW-1:0]        mul_b;
	logic [TW-1:0]        mul_acc;

	assign accept  = in_valid && !in_stall;
	assign proceed = !out_valid_q || !out_stall;
	assign red_idx = MOD_LUT[event_index];

	assign in_addr_ext = {{AW{1'b0}}, red_idx};
	assign wr_addr_ext = {{AW{1'b0}}, idx_q};

	emt_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_EVENTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	emt_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (mul_op),
		.a     (mul_a),
		.b     (mul_b),
		.acc   (mul_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= emt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_addr  = wr_addr_ext[AW-1:0];
		ram_wdata = entry_q;
		mul_op    = '0;
		mul_a     = d_q[HW-1:0];
		mul_b     = d_q[HW-1:0];
		unique case (state_q)
			emt_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(NUM_EVENTS - 1)) begin
					state_d = emt_pkg::ST_IDLE;
				end
			end
			emt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				ram_addr = in_addr_ext[AW-1:0];
				if (in_valid) begin
					state_d = emt_pkg::ST_FETCH;
				end
			end
			emt_pkg::ST_FETCH: begin
				if (req_q == emt_pkg::REQ_COUNT || rd_entry.mean == '0) begin
					state_d = emt_pkg::ST_WRITE;
				end else begin
					state_d = emt_pkg::ST_MEAN;
				end
			end
			emt_pkg::ST_MEAN: state_d = emt_pkg::ST_DIFF;
			emt_pkg::ST_DIFF: state_d = emt_pkg::ST_SQ0;
			// d*d from three 32x32 partial products
			emt_pkg::ST_SQ0: begin
				mul_op  = '{issue: 1'b1, clear: 1'b1, high: 1'b0};
				state_d = emt_pkg::ST_SQ1;
			end
			emt_pkg::ST_SQ1: begin
				mul_op  = '{issue: 1'b1, clear: 1'b0, high: 1'b1};
				mul_a   = d_q[TW-1:HW];
				state_d = emt_pkg::ST_SQ2;
			end
			emt_pkg::ST_SQ2: begin
				mul_op  = '{issue: 1'b1, clear: 1'b0, high: 1'b1};
				mul_b   = d_q[TW-1:HW];
				state_d = emt_pkg::ST_SQW;
			end
			emt_pkg::ST_SQW: state_d = emt_pkg::ST_VAR;
			// square is complete here; cube starts from it
			emt_pkg::ST_VAR: begin
				mul_op  = '{issue: 1'b1, clear: 1'b1, high: 1'b0};
				mul_a   = mul_acc[HW-1:0];
				state_d = emt_pkg::ST_CU1;
			end
			emt_pkg::ST_CU1: begin
				mul_op  = '{issue: 1'b1, clear: 1'b0, high: 1'b1};
				mul_a   = sq_q[TW-1:HW];
				state_d = emt_pkg::ST_CU2;
			end
			emt_pkg::ST_CU2: begin
				mul_op  = '{issue: 1'b1, clear: 1'b0, high: 1'b1};
				mul_a   = sq_q[HW-1:0];
				mul_b   = d_q[TW-1:HW];
				state_d = emt_pkg::ST_CUW;
			end
			emt_pkg::ST_CUW:   state_d = emt_pkg::ST_THIRD;
			emt_pkg::ST_THIRD: state_d = emt_pkg::ST_WRITE;
			emt_pkg::ST_WRITE: begin
				if (proceed) begin
					ram_we  = 1'b1;
					state_d = emt_pkg::ST_IDLE;
				end
			end
			default: state_d = emt_pkg::ST_CLEAR;
		endcase
	end

	assign rd_entry = emt_pkg::emt_entry_t'(ram_rdata);

	// count, total and kind, plus the mean seed, straight off the read word
	always_comb begin
		fetch_upd = rd_entry;
		if (req_q == emt_pkg::REQ_COUNT) begin
			fetch_upd.count = rd_entry.count + CW'(1) + cnt_q;
			fetch_upd.kind  = emt_pkg::KIND_COUNTED;
		end else begin
			fetch_upd.count = rd_entry.count + CW'(2);
			fetch_upd.total = rd_entry.total + t_q;
			if (rd_entry.mean == '0) begin
				fetch_upd.mean     = t_q;
				fetch_upd.variance = '0;
				fetch_upd.third    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == emt_pkg::ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			idx_q <= red_idx;
			t_q   <= sample_time;
			cnt_q <= event_count;
		end
		case (state_q)
			emt_pkg::ST_FETCH: entry_q <= fetch_upd;
			emt_pkg::ST_MEAN:  entry_q.mean <= smooth(entry_q.mean, t_q);
			emt_pkg::ST_DIFF:  d_q <= t_q - entry_q.mean;
			emt_pkg::ST_VAR: begin
				sq_q             <= mul_acc;
				entry_q.variance <= smooth(entry_q.variance, mul_acc);
			end
			emt_pkg::ST_THIRD: entry_q.third <= smooth(entry_q.third, mul_acc);
			default: ;
		endcase
		if (state_q == emt_pkg::ST_WRITE && proceed) begin
			out_q     <= entry_q;
			out_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == emt_pkg::ST_WRITE && proceed) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign entry_index    = out_idx_q;
	assign entry_count    = $signed(out_q.count);
	assign entry_total    = $signed(out_q.total);
	assign entry_mean     = $signed(out_q.mean);
	assign entry_variance = $signed(out_q.variance);
	assign entry_third    = $signed(out_q.third);
	assign entry_kind     = out_q.kind;

`ifndef SYNTH
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != emt_pkg::ST_CLEAR |=> state_q != emt_pkg::ST_CLEAR)
		else $error("clearing pass re-entered");

	a_out_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == emt_pkg::ST_WRITE)
		else $error("result word raised outside write-back");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == emt_pkg::ST_FETCH |-> idx_q < NUM_EVENTS)
		else $error("reduced index beyond table");

	a_count_skips_smooth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == emt_pkg::ST_MEAN |-> req_q == emt_pkg::REQ_TIMED)
		else $error("count event entered smoothing path");
`endif

endmodule
